>>> rtl/assert_macros.svh
// Assertion macros, included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression that must never hold at a clock edge.
`define ASSERT_NEVER(label, expr, msg) \
    `ASSERT_CLK(label, !(expr), msg)

`endif

>>> rtl/cba_pkg.sv
// Package: field widths, codes and default sizes of the block allocator.
`timescale 1ns / 1ps
`default_nettype none

package cba_pkg;

    localparam int CHANNELS_DEF = 4;
    localparam int BLOCKS_DEF   = 16;

    localparam int MODE_W   = 1;
    localparam int COUNT_W  = 5;
    localparam int FCH_W    = 2;
    localparam int FBLK_W   = 4;
    localparam int STATUS_W = 2;
    localparam int ACH_W    = 2;
    localparam int ABLK_W   = 4;

    localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_RESOURCE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND   = 2'd2;

endpackage

`default_nettype wire

>>> rtl/cba_rec_ram.sv
// Record RAM: run length per channel and start block, registered read.
`timescale 1ns / 1ps
`default_nettype none

module cba_rec_ram
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int WIDTH = 5
)
(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/cba_map_ram.sv
// Block map RAM: per channel the used bits and run start bits, with row valid flops.
`timescale 1ns / 1ps
`default_nettype none

module cba_map_ram
#(
    parameter int CHANNELS = 4,
    parameter int BLOCKS   = 16,
    parameter int CH_W     = 2
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [CH_W-1:0]       wr_addr,
    input  wire logic [2*BLOCKS-1:0]   wr_data,
    input  wire logic                  rd_en,
    input  wire logic [CH_W-1:0]       rd_addr,
    output logic      [2*BLOCKS-1:0]   rd_data
);

    logic [2*BLOCKS-1:0] mem [CHANNELS];
    logic [2*BLOCKS-1:0] rd_data_reg;
    logic [CHANNELS-1:0] row_valid_reg;
    logic [CHANNELS-1:0] row_valid_next;
    logic                rd_valid_reg;
    logic                rd_valid_next;

    // unwritten rows read as all blocks free
    always_comb
    begin
        row_valid_next = row_valid_reg;
        rd_valid_next  = rd_valid_reg;
        if (wr_en)
        begin
            row_valid_next[wr_addr] = 1'b1;
        end
        if (rd_en)
        begin
            rd_valid_next = row_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            rd_valid_reg  <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

>>> rtl/cba_first_fit.sv
// First-fit finder: lowest start in one channel row with count free blocks ahead.
`timescale 1ns / 1ps
`default_nettype none

module cba_first_fit
#(
    parameter int BLOCKS = 16,
    parameter int BLK_W  = 4,
    parameter int CNT_W  = 5
)
(
    input  wire logic [BLOCKS-1:0] used,
    input  wire logic [CNT_W-1:0]  count,
    output logic                   found,
    output logic      [BLK_W-1:0]  start
);

    logic [BLOCKS-1:0] thermo;
    logic [BLOCKS-1:0] fit;

    always_comb
    begin
        for (int i = 0; i < BLOCKS; i++)
        begin
            thermo[i] = (i < int'(count));
        end
        for (int k = 0; k < BLOCKS; k++)
        begin
            fit[k] = !(|(used & (thermo << k))) && ((k + int'(count)) <= BLOCKS);
        end
    end

    always_comb
    begin
        found = 1'b0;
        start = '0;
        for (int k = BLOCKS - 1; k >= 0; k--)
        begin
            if (fit[k])
            begin
                found = 1'b1;
                start = BLK_W'(k);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/contiguous_block_allocator_top.sv
// Top level: first-fit contiguous block allocator with sequencer and result register.
//
// Request channel (req_valid/req_ready): one word per request. mode selects
// allocate (block_count blocks) or free (free_channel, free_block).
// Response channel (rsp_valid/rsp_ready): one word per request with status,
// alloc_channel and alloc_block.
// One request is in work at a time; req_ready is high only when idle.
// Allocate: channel rows are read from the map RAM and scanned one at a time,
// from channel 0 up to the first row with a fit (1 to CHANNELS rows scanned).
// A count of zero or above BLOCKS answers with no scan.
// Free: map and record RAM read, then one write back.
// The next request is accepted the cycle after the response is loaded.
// A result waits in the sequencer while the response register is still held
// by a stalled receiver; further requests wait with it.
// Reset clears the row valid flops of the map RAM at once: all blocks free,
// no allocations. No clearing pass; requests are taken right after reset.
`timescale 1ns / 1ps
`default_nettype none

module contiguous_block_allocator_top
#(
    parameter int CHANNELS = cba_pkg::CHANNELS_DEF,
    parameter int BLOCKS   = cba_pkg::BLOCKS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire logic [cba_pkg::MODE_W-1:0]    mode,
    input  wire logic [cba_pkg::COUNT_W-1:0]   block_count,
    input  wire logic [cba_pkg::FCH_W-1:0]     free_channel,
    input  wire logic [cba_pkg::FBLK_W-1:0]    free_block,
    output logic                               rsp_valid,
    input  wire logic                          rsp_ready,
    output logic      [cba_pkg::STATUS_W-1:0]  status,
    output logic      [cba_pkg::ACH_W-1:0]     alloc_channel,
    output logic      [cba_pkg::ABLK_W-1:0]    alloc_block
);

    import cba_pkg::*;

    `include "assert_macros.svh"

    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int BLK_W     = $clog2(BLOCKS);
    localparam int CNT_W     = $clog2(BLOCKS + 1);
    localparam int REC_AW    = CH_W + BLK_W;
    localparam int REC_DEPTH = CHANNELS << BLK_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FREE = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    function automatic logic [BLOCKS-1:0] run_mask(input logic [BLK_W-1:0] s,
                                                   input logic [CNT_W-1:0] c);
        logic [BLOCKS-1:0] m;
        for (int i = 0; i < BLOCKS; i++)
        begin
            m[i] = (i >= int'(s)) && (i < (int'(s) + int'(c)));
        end
        return m;
    endfunction

    logic [1:0]          state_reg, state_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [BLK_W-1:0]    blk_reg, blk_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ACH_W-1:0]    res_ch_reg, res_ch_next;
    logic [ABLK_W-1:0]   res_blk_reg, res_blk_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic [ACH_W-1:0]    rsp_ch_reg;
    logic [ABLK_W-1:0]   rsp_blk_reg;
    logic                rsp_load;

    logic                map_rd_en;
    logic [CH_W-1:0]     map_rd_addr;
    logic [2*BLOCKS-1:0] map_rd_data;
    logic                map_wr_en;
    logic [CH_W-1:0]     map_wr_addr;
    logic [2*BLOCKS-1:0] map_wr_data;
    logic                rec_rd_en;
    logic [REC_AW-1:0]   rec_rd_addr;
    logic [CNT_W-1:0]    rec_rd_data;
    logic                rec_wr_en;
    logic [REC_AW-1:0]   rec_wr_addr;
    logic [CNT_W-1:0]    rec_wr_data;

    logic [BLOCKS-1:0]   row_used;
    logic [BLOCKS-1:0]   row_starts;
    logic                fit_found;
    logic [BLK_W-1:0]    fit_start;

    assign row_used   = map_rd_data[BLOCKS-1:0];
    assign row_starts = map_rd_data[2*BLOCKS-1:BLOCKS];

    cba_map_ram #(
        .CHANNELS (CHANNELS),
        .BLOCKS   (BLOCKS),
        .CH_W     (CH_W)
    ) u_map_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data),
        .rd_en   (map_rd_en),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data)
    );

    cba_rec_ram #(
        .DEPTH (REC_DEPTH),
        .AW    (REC_AW),
        .WIDTH (CNT_W)
    ) u_rec_ram (
        .clk     (clk),
        .wr_en   (rec_wr_en),
        .wr_addr (rec_wr_addr),
        .wr_data (rec_wr_data),
        .rd_en   (rec_rd_en),
        .rd_addr (rec_rd_addr),
        .rd_data (rec_rd_data)
    );

    cba_first_fit #(
        .BLOCKS (BLOCKS),
        .BLK_W  (BLK_W),
        .CNT_W  (CNT_W)
    ) u_first_fit (
        .used  (row_used),
        .count (cnt_reg),
        .found (fit_found),
        .start (fit_start)
    );

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        ch_next         = ch_reg;
        blk_next        = blk_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_ch_next     = res_ch_reg;
        res_blk_next    = res_blk_reg;
        rsp_load        = 1'b0;
        map_rd_en       = 1'b0;
        map_rd_addr     = ch_reg;
        map_wr_en       = 1'b0;
        map_wr_addr     = ch_reg;
        map_wr_data     = map_rd_data;
        rec_rd_en       = 1'b0;
        rec_rd_addr     = {ch_reg, blk_reg};
        rec_wr_en       = 1'b0;
        rec_wr_addr     = {ch_reg, fit_start};
        rec_wr_data     = cnt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    res_ch_next  = '0;
                    res_blk_next = '0;
                    if (mode == MODE_FREE)
                    begin
                        if ((int'(free_channel) < CHANNELS) && (int'(free_block) < BLOCKS))
                        begin
                            ch_next     = CH_W'(free_channel);
                            blk_next    = BLK_W'(free_block);
                            map_rd_en   = 1'b1;
                            map_rd_addr = CH_W'(free_channel);
                            rec_rd_en   = 1'b1;
                            rec_rd_addr = {CH_W'(free_channel), BLK_W'(free_block)};
                            state_next  = ST_FREE;
                        end
                        else
                        begin
                            res_status_next = STATUS_NOT_FOUND;
                            state_next      = ST_DONE;
                        end
                    end
                    else
                    begin
                        if ((block_count == '0) || (int'(block_count) > BLOCKS))
                        begin
                            res_status_next = STATUS_NO_RESOURCE;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            cnt_next    = CNT_W'(block_count);
                            ch_next     = '0;
                            map_rd_en   = 1'b1;
                            map_rd_addr = '0;
                            state_next  = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (fit_found)
                begin
                    map_wr_en       = 1'b1;
                    map_wr_data     = {row_starts | (BLOCKS'(1) << fit_start),
                                       row_used | run_mask(fit_start, cnt_reg)};
                    rec_wr_en       = 1'b1;
                    res_status_next = STATUS_OK;
                    res_ch_next     = ACH_W'(ch_reg);
                    res_blk_next    = ABLK_W'(fit_start);
                    state_next      = ST_DONE;
                end
                else if (int'(ch_reg) == (CHANNELS - 1))
                begin
                    res_status_next = STATUS_NO_RESOURCE;
                    state_next      = ST_DONE;
                end
                else
                begin
                    ch_next     = ch_reg + 1'b1;
                    map_rd_en   = 1'b1;
                    map_rd_addr = ch_reg + 1'b1;
                end
            end
            ST_FREE:
            begin
                if (row_starts[blk_reg])
                begin
                    map_wr_en       = 1'b1;
                    map_wr_data     = {row_starts & ~(BLOCKS'(1) << blk_reg),
                                       row_used & ~run_mask(blk_reg, rec_rd_data)};
                    res_status_next = STATUS_OK;
                end
                else
                begin
                    res_status_next = STATUS_NOT_FOUND;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg         <= ch_next;
        blk_reg        <= blk_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        res_ch_reg     <= res_ch_next;
        res_blk_reg    <= res_blk_next;
        if (rsp_load)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_ch_reg     <= res_ch_reg;
            rsp_blk_reg    <= res_blk_reg;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = rsp_status_reg;
    assign alloc_channel = rsp_ch_reg;
    assign alloc_block   = rsp_blk_reg;

    `ASSERT_CLK(a_map_wr_state,
        map_wr_en |-> (state_reg == ST_SCAN || state_reg == ST_FREE),
        "map write outside scan or free")
    `ASSERT_CLK(a_rsp_from_done,
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_DONE),
        "response not loaded from done")
    `ASSERT_CLK(a_run_in_range,
        (state_reg == ST_SCAN && fit_found) |-> ((int'(fit_start) + int'(cnt_reg)) <= BLOCKS),
        "granted run crosses channel end")
    `ASSERT_NEVER(a_scan_channel,
        (state_reg == ST_SCAN) && (int'(ch_reg) >= CHANNELS),
        "scan past last channel")

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Testbench for contiguous_block_allocator_top: random and directed requests against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import cba_pkg::*;

    localparam int NCH  = CHANNELS_DEF;
    localparam int NBLK = BLOCKS_DEF;
    localparam int NREC = NCH * NBLK;
    localparam int RANDOM_WORDS = 700;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ACH_W-1:0]    ch;
        logic [ABLK_W-1:0]   blk;
    } alloc_result_t;

    class alloc_scoreboard;
        logic [NBLK-1:0] used_map [NCH];
        bit              rec_valid [NREC];
        int              rec_ch    [NREC];
        int              rec_start [NREC];
        int              rec_cnt   [NREC];
        alloc_result_t   expected_q [$];
        int              failures;

        function new();
            for (int c = 0; c < NCH; c++)
                used_map[c] = '0;
            for (int i = 0; i < NREC; i++)
            begin
                rec_valid[i] = 1'b0;
                rec_ch[i]    = 0;
                rec_start[i] = 0;
                rec_cnt[i]   = 0;
            end
            failures = 0;
        endfunction

        function logic [NBLK-1:0] run_mask(int start, int cnt);
            logic [31:0] m;
            m = ((32'd1 << cnt) - 32'd1) << start;
            return m[NBLK-1:0];
        endfunction

        function alloc_result_t predict_alloc(int cnt);
            alloc_result_t   r;
            int              slot;
            logic [NBLK-1:0] run;
            r.status = STATUS_NO_RESOURCE;
            r.ch     = '0;
            r.blk    = '0;
            if (cnt == 0 || cnt > NBLK)
                return r;
            slot = -1;
            for (int i = 0; i < NREC; i++)
                if (!rec_valid[i] && slot < 0)
                    slot = i;
            if (slot < 0)
                return r;
            for (int c = 0; c < NCH; c++)
            begin
                for (int k = 0; k + cnt <= NBLK; k++)
                begin
                    run = run_mask(k, cnt);
                    if ((used_map[c] & run) == '0)
                    begin
                        used_map[c]     |= run;
                        rec_valid[slot] = 1'b1;
                        rec_ch[slot]    = c;
                        rec_start[slot] = k;
                        rec_cnt[slot]   = cnt;
                        r.status        = STATUS_OK;
                        r.ch            = c[ACH_W-1:0];
                        r.blk           = k[ABLK_W-1:0];
                        return r;
                    end
                end
            end
            return r;
        endfunction

        function logic [STATUS_W-1:0] predict_free(int ch, int blk);
            for (int i = 0; i < NREC; i++)
            begin
                if (rec_valid[i] && rec_ch[i] == ch && rec_start[i] == blk)
                begin
                    used_map[ch] &= ~run_mask(rec_start[i], rec_cnt[i]);
                    rec_valid[i] = 1'b0;
                    rec_cnt[i]   = 0;
                    return STATUS_OK;
                end
            end
            return STATUS_NOT_FOUND;
        endfunction

        function void note_request(logic [MODE_W-1:0] m, logic [COUNT_W-1:0] cnt,
                                   logic [FCH_W-1:0] fch, logic [FBLK_W-1:0] fblk);
            alloc_result_t r;
            if (m == MODE_ALLOC)
                r = predict_alloc(int'(cnt));
            else
            begin
                r.status = predict_free(int'(fch), int'(fblk));
                r.ch     = '0;
                r.blk    = '0;
            end
            expected_q.push_back(r);
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10)
                $display("%0t ERROR %s", $realtime, msg);
        endfunction

        function void check_response(logic [STATUS_W-1:0] st, logic [ACH_W-1:0] ch,
                                     logic [ABLK_W-1:0] blk);
            alloc_result_t e;
            if (expected_q.size() == 0)
            begin
                flag($sformatf("unexpected word status=%0d ch=%0d blk=%0d", st, ch, blk));
                return;
            end
            e = expected_q.pop_front();
            if (st !== e.status)
                flag($sformatf("status exp %0d got %0d", e.status, st));
            if (ch !== e.ch)
                flag($sformatf("alloc_channel exp %0d got %0d", e.ch, ch));
            if (blk !== e.blk)
                flag($sformatf("alloc_block exp %0d got %0d", e.blk, blk));
        endfunction

        function bit pick_live(output logic [FCH_W-1:0] ch, output logic [FBLK_W-1:0] blk);
            int live [$];
            int idx;
            for (int i = 0; i < NREC; i++)
                if (rec_valid[i])
                    live.push_back(i);
            if (live.size() == 0)
                return 1'b0;
            idx = live[$urandom_range(0, live.size() - 1)];
            ch  = rec_ch[idx][FCH_W-1:0];
            blk = rec_start[idx][FBLK_W-1:0];
            return 1'b1;
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    logic [MODE_W-1:0]   mode = MODE_ALLOC;
    logic [COUNT_W-1:0]  block_count = '0;
    logic [FCH_W-1:0]    free_channel = '0;
    logic [FBLK_W-1:0]   free_block = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [ACH_W-1:0]    alloc_channel;
    logic [ABLK_W-1:0]   alloc_block;

    int send_idle = 10;
    int recv_idle = 64;

    alloc_scoreboard sb = new();

    contiguous_block_allocator_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .mode         (mode),
        .block_count  (block_count),
        .free_channel (free_channel),
        .free_block   (free_block),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .status       (status),
        .alloc_channel(alloc_channel),
        .alloc_block  (alloc_block)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
        rsp_ready <= ($urandom_range(0, 99) >= recv_idle);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
                sb.check_response(status, alloc_channel, alloc_block);
            if (req_valid && req_ready)
                sb.note_request(mode, block_count, free_channel, free_block);
        end
    end

    // called at a rising edge; returns at the edge where the word is taken
    task automatic send_word(logic [MODE_W-1:0] m, logic [COUNT_W-1:0] cnt,
                             logic [FCH_W-1:0] fch, logic [FBLK_W-1:0] fblk);
        if ($urandom_range(0, 99) < send_idle)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle);
        end
        req_valid    <= 1'b1;
        mode         <= m;
        block_count  <= cnt;
        free_channel <= fch;
        free_block   <= fblk;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic send_alloc(int cnt);
        send_word(MODE_ALLOC, cnt[COUNT_W-1:0], FCH_W'($urandom), FBLK_W'($urandom));
    endtask

    task automatic send_free(int ch, int blk);
        send_word(MODE_FREE, COUNT_W'($urandom), ch[FCH_W-1:0], blk[FBLK_W-1:0]);
    endtask

    task automatic run_directed();
        send_alloc(0);
        send_alloc(17);
        send_alloc(31);
        send_alloc(16);
        send_alloc(16);
        send_alloc(16);
        send_alloc(15);
        send_alloc(2);
        send_alloc(1);
        send_alloc(1);
        send_free(3, 15);
        send_free(3, 15);
        send_free(0, 1);
        send_free(1, 0);
        send_free(0, 0);
        send_free(2, 0);
        send_free(3, 0);
        send_alloc(5);
        send_alloc(3);
        send_free(0, 0);
        send_alloc(4);
        send_alloc(2);
        send_alloc(8);
        send_free(0, 5);
        send_free(1, 0);
    endtask

    task automatic run_random(int words);
        int               roll;
        int               cnt;
        logic [FCH_W-1:0] fch;
        logic [FBLK_W-1:0] fblk;
        for (int i = 0; i < words; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 80)
                    cnt = $urandom_range(1, 6);
                else if (roll < 92)
                    cnt = $urandom_range(7, 16);
                else
                    cnt = $urandom_range(0, 31);
                send_alloc(cnt);
            end
            else if (roll < 88 && sb.pick_live(fch, fblk))
                send_word(MODE_FREE, COUNT_W'($urandom), fch, fblk);
            else
                send_free($urandom_range(0, NCH - 1), $urandom_range(0, NBLK - 1));
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random(RANDOM_WORDS / 3);
        send_idle = 64;
        recv_idle = 10;
        run_random(RANDOM_WORDS / 3);
        send_idle = 0;
        recv_idle = 0;
        run_random(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3));
        req_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.expected_q.size() != 0)
            sb.flag("words still expected at end");
        if (sb.failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

endmodule
